// ===== rtl/core/slcan_pkg.sv =====
// Package for the serial-line CAN command parser.
// Holds the item and result types, command and action codes and the hex decoder.
// No dependencies.
package slcan_pkg;

  localparam logic [7:0] CH_OPEN    = 8'h4F;  // 'O'
  localparam logic [7:0] CH_CLOSE   = 8'h43;  // 'C'
  localparam logic [7:0] CH_FRAME_L = 8'h74;  // 't'
  localparam logic [7:0] CH_FRAME_U = 8'h54;  // 'T'

  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_HEX_A   = 8'h41;
  localparam logic [7:0] CH_HEX_F   = 8'h46;

  localparam logic [3:0] MAX_LEN    = 4'd8;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;
  localparam logic [1:0] ACT_FRAME = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_of_command;
  } slcan_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        send_ack;
    logic        transmit;
    logic [11:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
  } slcan_result_t;

  // Uppercase hex digit to nibble; every other character decodes as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      v = c - CH_DIGIT_0;
    end else if (c >= CH_HEX_A && c <= CH_HEX_F) begin
      v = c - CH_HEX_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/core/slcan_command_parser.sv =====
// Top level of the serial-line CAN ASCII command parser.
// Depends on slcan_pkg, slcan_in_stage, slcan_parser and slcan_out_stage.
//
// Usage: one ASCII character of a command line arrives per in_ transaction,
// with in_last_of_command set on its final character. The first character
// picks the command ('O' open, 'C' close, 't' or 'T' frame); for a frame the
// next ID_DIGITS characters are the identifier, then one length digit, then
// pairs of data digits. Only the last character of a known command yields an
// out_ transaction; every other character yields none, and the parser state
// clears after each last character.
//
// The accepted last character sits in the input register, and its decoded
// result is captured in the result register at an edge on which that
// register has room; out_valid then offers it.
// Throughput: one character per cycle while out_ready keeps the result
// register from blocking, with a single decode step between the two registers.
// Reset (rst_n low, synchronous) empties both registers and clears the
// command state. When the receiver holds out_ready low with a result waiting,
// one more character is held in the input register and in_ready then drops
// until the result is taken.
module slcan_command_parser import slcan_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8,
  parameter int ID_DIGITS      = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_of_command,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic        out_send_ack,
  output logic        out_transmit,
  output logic [11:0] out_frame_id,
  output logic [3:0]  out_frame_length,
  output logic [63:0] out_frame_data
);

  slcan_item_t   in_item;
  slcan_item_t   item;
  logic          item_valid;
  logic          advance;
  logic          res_valid;
  slcan_result_t res;
  slcan_result_t out_res;

  assign in_item.byte_value      = in_byte_value;
  assign in_item.last_of_command = in_last_of_command;

  slcan_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  slcan_parser #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .ID_DIGITS      (ID_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  slcan_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_action       = out_res.action;
  assign out_send_ack     = out_res.send_ack;
  assign out_transmit     = out_res.transmit;
  assign out_frame_id     = out_res.frame_id;
  assign out_frame_length = out_res.frame_length;
  assign out_frame_data   = out_res.frame_data;

  // A result is only formed when the result register has room for it.
  a_res_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_valid || out_ready)
    else $error("result formed while result register is blocked");

endmodule

// ===== rtl/core/slcan_in_stage.sv =====
// Input register of the command parser: holds one accepted character.
// Depends on slcan_pkg.
module slcan_in_stage import slcan_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  slcan_item_t in_item,
  input  logic        advance,
  output logic        item_valid,
  output slcan_item_t item
);

  logic        valid_r, valid_nxt;
  slcan_item_t item_r, item_nxt;

  // The held character leaves whenever the parser steps, so a new one may enter.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/slcan_parser.sv =====
// Command state and decode of the parser: accumulates one command line and
// forms the result on its last character. Depends on slcan_pkg.
module slcan_parser import slcan_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8,
  parameter int ID_DIGITS      = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  slcan_item_t   item,
  input  logic          advance,
  output logic          res_valid,
  output slcan_result_t res
);

  localparam int         DATA_W  = 8 * MAX_DATA_BYTES;
  localparam int         NIBBLES = 2 * MAX_DATA_BYTES;
  localparam logic [4:0] ID_LAST = 5'(ID_DIGITS);
  localparam logic [4:0] LEN_POS = 5'(ID_DIGITS + 1);
  localparam logic [4:0] POS_MAX = 5'd31;

  logic [4:0]        pos_r, pos_nxt;
  logic [7:0]        letter_r, letter_nxt;
  logic [11:0]       id_r, id_nxt;
  logic [3:0]        len_r, len_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  logic              do_step;
  logic [3:0]        nib;
  logic [7:0]        letter_cur;
  logic [11:0]       id_cur;
  logic [3:0]        len_cur;
  logic [DATA_W-1:0] data_cur;
  logic [DATA_W-1:0] data_masked;
  logic              is_frame;
  logic              known;
  logic              tx_ok;

  assign do_step = item_valid && advance;
  assign nib     = hex_value(item.byte_value);

  // State as it stands once this character is taken in.
  always_comb begin
    letter_cur = (pos_r == 5'd0) ? item.byte_value : letter_r;
    id_cur     = (pos_r != 5'd0 && pos_r <= ID_LAST) ? {id_r[7:0], nib} : id_r;
    len_cur    = (pos_r == LEN_POS) ? nib : len_r;
    data_cur   = data_r;
    // Even data digits are the high nibble of a byte, odd ones the low nibble.
    for (int k = 0; k < NIBBLES; k++) begin
      if (pos_r == 5'(ID_DIGITS + 2 + k)) begin
        data_cur[8 * (k >> 1) + ((k & 1) == 0 ? 4 : 0) +: 4] = nib;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < MAX_DATA_BYTES; b++) begin
      data_masked[8 * b +: 8] = (4'(b) < len_cur) ? data_cur[8 * b +: 8] : 8'd0;
    end
  end

  assign is_frame = (letter_cur == CH_FRAME_L) || (letter_cur == CH_FRAME_U);
  assign known    = (letter_cur == CH_OPEN) || (letter_cur == CH_CLOSE) || is_frame;
  assign tx_ok    = is_frame && (id_cur != 12'd0) && (len_cur <= MAX_LEN);

  assign res_valid = do_step && item.last_of_command && known;

  always_comb begin
    res = '0;
    priority if (letter_cur == CH_OPEN) begin
      res.action = ACT_OPEN;
    end else if (letter_cur == CH_CLOSE) begin
      res.action   = ACT_CLOSE;
      res.send_ack = 1'b1;
    end else if (is_frame) begin
      res.action   = ACT_FRAME;
      res.send_ack = 1'b1;
      if (tx_ok) begin
        res.transmit     = 1'b1;
        res.frame_id     = id_cur;
        res.frame_length = len_cur;
        res.frame_data   = 64'(data_masked);
      end
    end else begin
      res.action = ACT_NONE;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    letter_nxt = letter_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    data_nxt   = data_r;
    if (do_step) begin
      if (item.last_of_command) begin
        pos_nxt    = 5'd0;
        letter_nxt = 8'd0;
        id_nxt     = 12'd0;
        len_nxt    = 4'd0;
        data_nxt   = '0;
      end else begin
        pos_nxt    = (pos_r == POS_MAX) ? pos_r : pos_r + 5'd1;
        letter_nxt = letter_cur;
        id_nxt     = id_cur;
        len_nxt    = len_cur;
        data_nxt   = data_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 5'd0;
      letter_r <= 8'd0;
      id_r     <= 12'd0;
      len_r    <= 4'd0;
      data_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      letter_r <= letter_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      data_r   <= data_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_step && item.last_of_command |=> pos_r == 5'd0 && id_r == 12'd0)
    else $error("command state not cleared after last character");

  a_tx_is_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.transmit |-> res.action == ACT_FRAME && res.frame_length <= MAX_LEN)
    else $error("transmit outside a valid frame command");

  a_no_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.transmit |->
      res.frame_id == 12'd0 && res.frame_length == 4'd0 && res.frame_data == 64'd0)
    else $error("frame fields not zero without transmit");

endmodule

// ===== rtl/core/slcan_out_stage.sv =====
// Result register of the command parser, drained by the out_ channel.
// Depends on slcan_pkg.
module slcan_out_stage import slcan_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  slcan_result_t res,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_ready,
  output slcan_result_t out_res
);

  logic          valid_r, valid_nxt;
  slcan_result_t res_r, res_nxt;

  // The parser may step whenever the result register is empty or being emptied.
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (advance) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== tb/slcan_reply_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the serial-line CAN command parser: predicts each reply from the
// characters it sees accepted and compares the replies that leave the block.
// Depends on slcan_pkg for the reply type, command characters and action codes.
module slcan_reply_checker import slcan_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8,
  parameter int ID_DIGITS      = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_of_command,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_action,
  input  logic        out_send_ack,
  input  logic        out_transmit,
  input  logic [11:0] out_frame_id,
  input  logic [3:0]  out_frame_length,
  input  logic [63:0] out_frame_data,
  output int          error_count,
  output int          pending_count
);

  // Mirror of the parser's command state.
  logic [4:0]  char_pos;
  logic [7:0]  cmd_char;
  logic [11:0] id_acc;
  logic [3:0]  len_nib;
  logic [63:0] data_acc;

  slcan_result_t expected_replies[$];

  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return 4'(ch - "0");
    if (ch >= "A" && ch <= "F") return 4'(ch - "A" + 8'd10);
    return 4'd0;
  endfunction

  task automatic clear_command();
    char_pos = '0;
    cmd_char = '0;
    id_acc   = '0;
    len_nib  = '0;
    data_acc = '0;
  endtask

  task automatic parse_char(input logic [7:0] ch, input logic last);
    logic [3:0]    nib;
    int            d;
    int            sh;
    logic          known;
    slcan_result_t r;
    nib = nibble_of(ch);
    if (char_pos == 0) begin
      cmd_char = ch;
    end else if (char_pos <= ID_DIGITS) begin
      id_acc = {id_acc[7:0], nib};
    end else if (char_pos == ID_DIGITS + 1) begin
      len_nib = nib;
    end else begin
      d = int'(char_pos) - (ID_DIGITS + 2);
      if (d < 2 * MAX_DATA_BYTES) begin
        sh = 8 * (d / 2) + ((d % 2 == 0) ? 4 : 0);
        data_acc = data_acc | (64'(nib) << sh);
      end
    end
    if (char_pos != 5'd31) char_pos = char_pos + 5'd1;

    if (last) begin
      r = '0;
      known = 1'b1;
      case (cmd_char)
        CH_OPEN: begin
          r.action = ACT_OPEN;
        end
        CH_CLOSE: begin
          r.action   = ACT_CLOSE;
          r.send_ack = 1'b1;
        end
        CH_FRAME_L, CH_FRAME_U: begin
          r.action   = ACT_FRAME;
          r.send_ack = 1'b1;
          if (id_acc != 0 && len_nib <= MAX_LEN) begin
            r.transmit     = 1'b1;
            r.frame_id     = id_acc;
            r.frame_length = len_nib;
            if (len_nib >= MAX_LEN) r.frame_data = data_acc;
            else r.frame_data = data_acc & ((64'd1 << (8 * len_nib)) - 64'd1);
          end
        end
        default: begin
          known = 1'b0;
        end
      endcase
      if (known) expected_replies.push_back(r);
      clear_command();
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      error_count++;
    end
  endtask

  initial clear_command();

  always @(posedge clk) begin
    slcan_result_t want;
    if (!rst_n) begin
      clear_command();
      expected_replies.delete();
    end else begin
      if (in_valid && in_ready) parse_char(in_byte_value, in_last_of_command);
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with none expected: action %0d", out_action);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("action", want.action, out_action);
          compare_field("send_ack", want.send_ack, out_send_ack);
          compare_field("transmit", want.transmit, out_transmit);
          compare_field("frame_id", want.frame_id, out_frame_id);
          compare_field("frame_length", want.frame_length, out_frame_length);
          compare_field("frame_data", want.frame_data, out_frame_data);
        end
      end
    end
    pending_count = expected_replies.size();
  end

endmodule

// ===== tb/tb_slcan_command_parser.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the serial-line CAN command parser.
// Depends on slcan_pkg, slcan_command_parser and slcan_reply_checker.
module tb_slcan_command_parser;
  import slcan_pkg::*;

  // Traffic phases. Each random phase sends roughly the same number of
  // characters under a different pattern of idling on the two channels.
  localparam int PH_DIRECTED    = 0;
  localparam int PH_SEND_IDLE   = 1;
  localparam int PH_RECV_STALL  = 2;
  localparam int PH_BOTH_IDLE   = 3;
  localparam int PH_PRESSURE    = 4;
  localparam int PH_STEADY      = 5;

  localparam int CHARS_PER_PHASE = 100;
  // The receiver refuses replies this long in the pressure phase, which is far
  // more than the two registers inside the block can absorb.
  localparam int HOLD_CYCLES     = 300;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT     = 3000;
  // Margin after the last expected reply, so that a stray reply would still be seen.
  localparam int DRAIN_CYCLES    = 20;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic [7:0]  in_byte_value      = 8'h00;
  logic        in_last_of_command = 1'b0;
  logic        out_ready          = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_action;
  logic        out_send_ack;
  logic        out_transmit;
  logic [11:0] out_frame_id;
  logic [3:0]  out_frame_length;
  logic [63:0] out_frame_data;

  int phase         = PH_DIRECTED;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int chars_sent    = 0;
  int idle_cycles   = 0;
  int error_count;
  int pending_count;

  // Characters of the command line that is about to be sent.
  logic [7:0] line_buf[$];

  always #5 clk = ~clk;

  slcan_command_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_value      (in_byte_value),
    .in_last_of_command (in_last_of_command),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_send_ack       (out_send_ack),
    .out_transmit       (out_transmit),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_frame_data     (out_frame_data)
  );

  slcan_reply_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_value      (in_byte_value),
    .in_last_of_command (in_last_of_command),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_send_ack       (out_send_ack),
    .out_transmit       (out_transmit),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_frame_data     (out_frame_data),
    .error_count        (error_count),
    .pending_count      (pending_count)
  );

  // Converts a nibble to its uppercase ASCII hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_DIGIT_0 + 8'(n);
    return CH_HEX_A + 8'(n - 4'd10);
  endfunction

  // Offers one character and returns once the block has taken it. Before the
  // offer the sender may idle for a random number of cycles. At most one
  // assignment to in_valid is made per clock edge, so a valid that stays high
  // from one transaction into the next is never pulsed low.
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_byte_value      <= ch;
    in_last_of_command <= last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // Sends the buffered line, marking its final character as the last one.
  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  // Builds one random command line. Most lines are frame commands with
  // random content, since only those reach the identifier, length and data
  // decoding. The rest are open and close commands, unknown command letters
  // and raw noise, which also drives every bit of the character field.
  task automatic build_random_line();
    int         kind;
    int         len;
    int         pairs;
    logic [7:0] first;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      line_buf.push_back($urandom_range(0, 1) ? CH_FRAME_L : CH_FRAME_U);
      // A zero identifier is rare by chance, so it is forced now and then.
      if ($urandom_range(0, 15) == 0) begin
        repeat (3) line_buf.push_back(CH_DIGIT_0);
      end else begin
        repeat (3) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      line_buf.push_back(hex_char(4'(len)));
      // Usually as many data pairs as the length asks for, sometimes more or
      // fewer so that missing and surplus digits show up.
      if ($urandom_range(0, 3) == 0) pairs = $urandom_range(0, 9);
      else pairs = (len > 8) ? 8 : len;
      repeat (pairs) begin
        line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 7) == 0) void'(line_buf.pop_back());
    end else if (kind < 80) begin
      line_buf.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
      repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      do first = 8'($urandom_range(0, 255));
      while (first == CH_OPEN || first == CH_CLOSE ||
             first == CH_FRAME_L || first == CH_FRAME_U);
      line_buf.push_back(first);
      repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Noise, sometimes behind a frame letter and long enough to run the
      // character position into saturation.
      if ($urandom_range(0, 1)) line_buf.push_back(CH_FRAME_L);
      else line_buf.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 36)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver. It stalls at random according to the current phase, and once, at
  // the start of the pressure phase, refuses replies for a long stretch so the
  // block fills up and has to hold off the sender.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_PRESSURE && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog. Any cycle with a transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] len_char;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands, sent back to back with the receiver always ready.
    send_text("O");
    send_text("C");
    line_buf.push_back(8'hFF);             // unknown letter, all bits set
    send_line();
    line_buf.push_back(8'h00);             // unknown letter, all bits clear
    send_line();
    send_text("T1F");                      // identifier cut short
    send_text("t0002AB");                  // zero identifier, no frame issued
    send_text("t7FF9AABB");                // length above eight, no frame issued
    send_text("tFFF80123456789ABCDEFZZ");  // full frame with surplus characters
    send_text("t1232FFFFFFFF");            // data beyond the length is dropped
    send_text("ta3b1c");                   // lowercase hex decodes as zero
    send_text("Ohello");                   // open with trailing characters
    send_text("t0010");                    // length zero frame
    // A line well past 31 characters, so the position counter saturates.
    len_char = hex_char(4'd8);
    line_buf.push_back(CH_FRAME_U);
    line_buf.push_back(hex_char(4'd1));
    line_buf.push_back(hex_char(4'd2));
    line_buf.push_back(hex_char(4'd3));
    line_buf.push_back(len_char);
    repeat (35) line_buf.push_back(hex_char(4'd10));
    send_line();

    // Random traffic, one phase after another.
    for (int p = PH_SEND_IDLE; p <= PH_STEADY; p++) begin
      case (p)
        PH_SEND_IDLE: begin
          send_idle_pct = 79;
          stall_pct     = 0;
        end
        PH_RECV_STALL: begin
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        PH_BOTH_IDLE: begin
          send_idle_pct = 18;
          stall_pct     = 18;
        end
        PH_PRESSURE: begin
          send_idle_pct = 0;
          stall_pct     = 30;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      phase      = p;
      chars_sent = 0;
      while (chars_sent < CHARS_PER_PHASE) begin
        build_random_line();
        send_line();
      end
    end

    // Stop offering, wait for every expected reply, then let the pipeline
    // settle so a stray reply would still be seen.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== slcan_command_parser.f =====
rtl/core/slcan_pkg.sv
rtl/core/slcan_in_stage.sv
rtl/core/slcan_parser.sv
rtl/core/slcan_out_stage.sv
rtl/core/slcan_command_parser.sv
tb/slcan_reply_checker.sv
tb/tb_slcan_command_parser.sv
